FILE: rtl/core/strided_block_move_address_gen_defines.svh
// ============================================================================
// strided block move address generator assertion macros
// shared property forms used by the core rtl
// ============================================================================
`ifndef STRIDED_BLOCK_MOVE_ADDRESS_GEN_DEFINES_SVH
`define STRIDED_BLOCK_MOVE_ADDRESS_GEN_DEFINES_SVH

// same-cycle implication
`define SBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbm assertion failed");

// next-cycle implication
`define SBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbm assertion failed");

`endif

FILE: rtl/core/sbm_pkg.sv
// ============================================================================
// sbm_pkg
// types and constants shared by the strided block move address generator
// ============================================================================
package sbm_pkg;

    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;
    localparam int START_W      = 40;
    localparam int OUT_ADDR_W   = 48;
    localparam int IDX_W        = 16;
    localparam int ROW_STEP_W   = 26;
    localparam int BLOCK_STEP_W = 42;
    localparam int SPAN_W       = 43;
    localparam int ROW_BYTES_W  = 25;
    localparam int WIDTH_W      = 23;
    localparam int COUNT_W      = 17;

    localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = 23'h400000;
    localparam logic [COUNT_W-1:0] DEFAULT_COUNT = 17'h10000;

    localparam logic [2:0] ET_HALF_A = 3'd0;
    localparam logic [2:0] ET_HALF_B = 3'd1;
    localparam logic [2:0] ET_WORD   = 3'd2;
    localparam logic [2:0] ET_BYTE   = 3'd3;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } opcode_t;

    typedef enum logic [2:0]
    {
        ST_STARTED     = 3'd0,
        ST_ROW         = 3'd1,
        ST_BAD_TYPE    = 3'd2,
        ST_ROW_SHORT   = 3'd3,
        ST_BLOCK_SHORT = 3'd4,
        ST_IDLE        = 3'd5
    } status_t;

    typedef enum logic [2:0]
    {
        REG_ELEMENT_TYPE     = 3'd0,
        REG_ROW_WIDTH        = 3'd1,
        REG_ROW_COUNT        = 3'd2,
        REG_BLOCK_COUNT      = 3'd3,
        REG_SRC_ROW_STRIDE   = 3'd4,
        REG_SRC_BLOCK_STRIDE = 3'd5,
        REG_DST_ROW_STRIDE   = 3'd6,
        REG_DST_BLOCK_STRIDE = 3'd7
    } reg_idx_t;

    typedef struct packed
    {
        logic [2:0]  element_type;
        logic [21:0] row_width;
        logic [15:0] row_count;
        logic [15:0] block_count;
        logic [23:0] src_row_stride;
        logic [31:0] src_block_stride;
        logic [23:0] dst_row_stride;
        logic [31:0] dst_block_stride;
    } cfg_t;

    typedef struct packed
    {
        logic       ok;
        logic [1:0] shift;
    } esz_t;

    function automatic esz_t elem_size(input logic [2:0] t);
        esz_t r;
        begin
            case (t)
                ET_HALF_A, ET_HALF_B:
                begin
                    r.ok    = 1'b1;
                    r.shift = 2'd1;
                end
                ET_WORD:
                begin
                    r.ok    = 1'b1;
                    r.shift = 2'd2;
                end
                ET_BYTE:
                begin
                    r.ok    = 1'b1;
                    r.shift = 2'd0;
                end
                default:
                begin
                    r.ok    = 1'b0;
                    r.shift = 2'd0;
                end
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/sbm_cfg.sv
// ============================================================================
// sbm_cfg
// apb register file holding the transfer shape and strides
// ============================================================================
module sbm_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbm_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbm_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output sbm_pkg::cfg_t                cfg
);

    sbm_pkg::cfg_t    cfg_reg;
    sbm_pkg::cfg_t    cfg_next;
    sbm_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = sbm_pkg::reg_idx_t'(paddr[sbm_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                sbm_pkg::REG_ELEMENT_TYPE:     cfg_next.element_type     = pwdata[2:0];
                sbm_pkg::REG_ROW_WIDTH:        cfg_next.row_width        = pwdata[21:0];
                sbm_pkg::REG_ROW_COUNT:        cfg_next.row_count        = pwdata[15:0];
                sbm_pkg::REG_BLOCK_COUNT:      cfg_next.block_count      = pwdata[15:0];
                sbm_pkg::REG_SRC_ROW_STRIDE:   cfg_next.src_row_stride   = pwdata[23:0];
                sbm_pkg::REG_SRC_BLOCK_STRIDE: cfg_next.src_block_stride = pwdata[31:0];
                sbm_pkg::REG_DST_ROW_STRIDE:   cfg_next.dst_row_stride   = pwdata[23:0];
                sbm_pkg::REG_DST_BLOCK_STRIDE: cfg_next.dst_block_stride = pwdata[31:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sbm_pkg::REG_ELEMENT_TYPE:     prdata = 32'(cfg_reg.element_type);
            sbm_pkg::REG_ROW_WIDTH:        prdata = 32'(cfg_reg.row_width);
            sbm_pkg::REG_ROW_COUNT:        prdata = 32'(cfg_reg.row_count);
            sbm_pkg::REG_BLOCK_COUNT:      prdata = 32'(cfg_reg.block_count);
            sbm_pkg::REG_SRC_ROW_STRIDE:   prdata = 32'(cfg_reg.src_row_stride);
            sbm_pkg::REG_SRC_BLOCK_STRIDE: prdata = cfg_reg.src_block_stride;
            sbm_pkg::REG_DST_ROW_STRIDE:   prdata = 32'(cfg_reg.dst_row_stride);
            sbm_pkg::REG_DST_BLOCK_STRIDE: prdata = cfg_reg.dst_block_stride;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/strided_block_move_address_gen.sv
// ============================================================================
// strided_block_move_address_gen
// three-dimensional strided dma address generator, one row move per beat
// capture: a beat goes to the input register on accept and its result to the
//   result register once the result side can take it
// throughput: one beat per cycle unless the result side stalls, set by the
//   single compute stage between the input register and the result register
// reset: rst_n clears the registers, the transfer state and all control
// ============================================================================
`include "strided_block_move_address_gen_defines.svh"

module strided_block_move_address_gen
#(
    parameter int ADDR_BITS = 48
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbm_pkg::PADDR_W-1:0]     paddr,
    input  logic [sbm_pkg::PDATA_W-1:0]     pwdata,
    output logic [sbm_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [sbm_pkg::START_W-1:0]     src_start,
    input  logic [sbm_pkg::START_W-1:0]     dst_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sbm_pkg::OUT_ADDR_W-1:0]  src_row_addr,
    output logic [sbm_pkg::OUT_ADDR_W-1:0]  dst_row_addr,
    output logic [sbm_pkg::ROW_BYTES_W-1:0] byte_count,
    output logic                            last,
    output logic [2:0]                      status
);

    sbm_pkg::cfg_t cfg;

    // input register
    logic                        in_vld_reg, in_vld_next;
    sbm_pkg::opcode_t            in_op_reg, in_op_next;
    logic [sbm_pkg::START_W-1:0] in_src_reg, in_src_next;
    logic [sbm_pkg::START_W-1:0] in_dst_reg, in_dst_next;

    // transfer state
    logic                             active_reg, active_next;
    logic [sbm_pkg::IDX_W-1:0]        row_idx_reg, row_idx_next;
    logic [sbm_pkg::IDX_W-1:0]        blk_idx_reg, blk_idx_next;
    logic [ADDR_BITS-1:0]             src_row_ptr_reg, src_row_ptr_next;
    logic [ADDR_BITS-1:0]             dst_row_ptr_reg, dst_row_ptr_next;
    logic [ADDR_BITS-1:0]             src_blk_ptr_reg, src_blk_ptr_next;
    logic [ADDR_BITS-1:0]             dst_blk_ptr_reg, dst_blk_ptr_next;
    logic [sbm_pkg::ROW_STEP_W-1:0]   src_row_step_reg, src_row_step_next;
    logic [sbm_pkg::ROW_STEP_W-1:0]   dst_row_step_reg, dst_row_step_next;
    logic [sbm_pkg::BLOCK_STEP_W-1:0] src_blk_step_reg, src_blk_step_next;
    logic [sbm_pkg::BLOCK_STEP_W-1:0] dst_blk_step_reg, dst_blk_step_next;
    logic [sbm_pkg::ROW_BYTES_W-1:0]  row_bytes_reg, row_bytes_next;

    // result register
    logic                            out_vld_reg, out_vld_next;
    logic [sbm_pkg::OUT_ADDR_W-1:0]  out_src_reg, out_src_next;
    logic [sbm_pkg::OUT_ADDR_W-1:0]  out_dst_reg, out_dst_next;
    logic [sbm_pkg::ROW_BYTES_W-1:0] out_cnt_reg, out_cnt_next;
    logic                            out_last_reg, out_last_next;
    sbm_pkg::status_t                out_status_reg, out_status_next;

    // start setup
    sbm_pkg::esz_t                    esz;
    logic [sbm_pkg::WIDTH_W-1:0]      w;
    logic [sbm_pkg::COUNT_W-1:0]      h;
    logic [23:0]                      src_pitch_el, dst_pitch_el;
    logic [sbm_pkg::ROW_STEP_W-1:0]   src_row_step_calc, dst_row_step_calc;
    logic [sbm_pkg::SPAN_W-1:0]       src_span, dst_span;
    logic [33:0]                      src_blk_scaled, dst_blk_scaled;
    logic [sbm_pkg::SPAN_W-1:0]       src_blk_step_calc, dst_blk_step_calc;
    logic                             row_short, block_short;
    logic [sbm_pkg::ROW_BYTES_W-1:0]  row_bytes_calc;
    logic [ADDR_BITS-1:0]             src_start_ptr, dst_start_ptr;

    // advance control
    logic proceed;
    logic end_block, end_all;

    sbm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign proceed  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proceed;

    assign out_valid    = out_vld_reg;
    assign src_row_addr = out_src_reg;
    assign dst_row_addr = out_dst_reg;
    assign byte_count   = out_cnt_reg;
    assign last         = out_last_reg;
    assign status       = out_status_reg;

    always_comb
    begin
        esz = sbm_pkg::elem_size(cfg.element_type);
        w   = (cfg.row_width == '0) ? sbm_pkg::DEFAULT_WIDTH
                                    : sbm_pkg::WIDTH_W'(cfg.row_width);
        h   = (cfg.row_count == '0) ? sbm_pkg::DEFAULT_COUNT
                                    : sbm_pkg::COUNT_W'(cfg.row_count);

        src_pitch_el = (cfg.src_row_stride == '0) ? 24'(w) : cfg.src_row_stride;
        dst_pitch_el = (cfg.dst_row_stride == '0) ? 24'(w) : cfg.dst_row_stride;

        src_row_step_calc = sbm_pkg::ROW_STEP_W'(src_pitch_el) << esz.shift;
        dst_row_step_calc = sbm_pkg::ROW_STEP_W'(dst_pitch_el) << esz.shift;

        src_span = sbm_pkg::SPAN_W'(src_row_step_calc) * sbm_pkg::SPAN_W'(h);
        dst_span = sbm_pkg::SPAN_W'(dst_row_step_calc) * sbm_pkg::SPAN_W'(h);

        src_blk_scaled = 34'(cfg.src_block_stride) << esz.shift;
        dst_blk_scaled = 34'(cfg.dst_block_stride) << esz.shift;

        src_blk_step_calc = (cfg.src_block_stride == '0) ? src_span
                                                         : sbm_pkg::SPAN_W'(src_blk_scaled);
        dst_blk_step_calc = (cfg.dst_block_stride == '0) ? dst_span
                                                         : sbm_pkg::SPAN_W'(dst_blk_scaled);

        row_short   = (src_pitch_el < 24'(w)) || (dst_pitch_el < 24'(w));
        block_short = (src_blk_step_calc < src_span) || (dst_blk_step_calc < dst_span);

        row_bytes_calc = sbm_pkg::ROW_BYTES_W'(w) << esz.shift;

        src_start_ptr = ADDR_BITS'(in_src_reg);
        dst_start_ptr = ADDR_BITS'(in_dst_reg);
    end

    assign end_block = (row_idx_reg == (cfg.row_count - 16'd1));
    assign end_all   = end_block && (blk_idx_reg == (cfg.block_count - 16'd1));

    always_comb
    begin
        in_vld_next = in_vld_reg;
        in_op_next  = in_op_reg;
        in_src_next = in_src_reg;
        in_dst_next = in_dst_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
            in_op_next  = sbm_pkg::opcode_t'(opcode);
            in_src_next = src_start;
            in_dst_next = dst_start;
        end
        else if (proceed)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        active_next       = active_reg;
        row_idx_next      = row_idx_reg;
        blk_idx_next      = blk_idx_reg;
        src_row_ptr_next  = src_row_ptr_reg;
        dst_row_ptr_next  = dst_row_ptr_reg;
        src_blk_ptr_next  = src_blk_ptr_reg;
        dst_blk_ptr_next  = dst_blk_ptr_reg;
        src_row_step_next = src_row_step_reg;
        dst_row_step_next = dst_row_step_reg;
        src_blk_step_next = src_blk_step_reg;
        dst_blk_step_next = dst_blk_step_reg;
        row_bytes_next    = row_bytes_reg;

        out_vld_next    = out_vld_reg;
        out_src_next    = out_src_reg;
        out_dst_next    = out_dst_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        if (proceed)
        begin
            out_vld_next  = 1'b1;
            out_src_next  = '0;
            out_dst_next  = '0;
            out_cnt_next  = '0;
            out_last_next = 1'b0;

            if (in_op_reg == sbm_pkg::OP_START)
            begin
                active_next = 1'b0;
                priority if (!esz.ok)
                begin
                    out_status_next = sbm_pkg::ST_BAD_TYPE;
                end
                else if (row_short)
                begin
                    out_status_next = sbm_pkg::ST_ROW_SHORT;
                end
                else if (block_short)
                begin
                    out_status_next = sbm_pkg::ST_BLOCK_SHORT;
                end
                else
                begin
                    active_next       = 1'b1;
                    row_idx_next      = '0;
                    blk_idx_next      = '0;
                    src_row_ptr_next  = src_start_ptr;
                    dst_row_ptr_next  = dst_start_ptr;
                    src_blk_ptr_next  = src_start_ptr;
                    dst_blk_ptr_next  = dst_start_ptr;
                    src_row_step_next = src_row_step_calc;
                    dst_row_step_next = dst_row_step_calc;
                    src_blk_step_next = sbm_pkg::BLOCK_STEP_W'(src_blk_step_calc);
                    dst_blk_step_next = sbm_pkg::BLOCK_STEP_W'(dst_blk_step_calc);
                    row_bytes_next    = row_bytes_calc;
                    out_src_next      = sbm_pkg::OUT_ADDR_W'(src_start_ptr);
                    out_dst_next      = sbm_pkg::OUT_ADDR_W'(dst_start_ptr);
                    out_status_next   = sbm_pkg::ST_STARTED;
                end
            end
            else if (!active_reg)
            begin
                out_status_next = sbm_pkg::ST_IDLE;
            end
            else
            begin
                out_src_next    = sbm_pkg::OUT_ADDR_W'(src_row_ptr_reg);
                out_dst_next    = sbm_pkg::OUT_ADDR_W'(dst_row_ptr_reg);
                out_cnt_next    = row_bytes_reg;
                out_last_next   = end_all;
                out_status_next = sbm_pkg::ST_ROW;
                priority if (end_all)
                begin
                    active_next = 1'b0;
                end
                else if (end_block)
                begin
                    row_idx_next     = '0;
                    blk_idx_next     = blk_idx_reg + 16'd1;
                    src_blk_ptr_next = src_blk_ptr_reg + ADDR_BITS'(src_blk_step_reg);
                    dst_blk_ptr_next = dst_blk_ptr_reg + ADDR_BITS'(dst_blk_step_reg);
                    src_row_ptr_next = src_blk_ptr_reg + ADDR_BITS'(src_blk_step_reg);
                    dst_row_ptr_next = dst_blk_ptr_reg + ADDR_BITS'(dst_blk_step_reg);
                end
                else
                begin
                    row_idx_next     = row_idx_reg + 16'd1;
                    src_row_ptr_next = src_row_ptr_reg + ADDR_BITS'(src_row_step_reg);
                    dst_row_ptr_next = dst_row_ptr_reg + ADDR_BITS'(dst_row_step_reg);
                end
            end
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            in_op_reg        <= sbm_pkg::OP_START;
            in_src_reg       <= '0;
            in_dst_reg       <= '0;
            active_reg       <= 1'b0;
            row_idx_reg      <= '0;
            blk_idx_reg      <= '0;
            src_row_ptr_reg  <= '0;
            dst_row_ptr_reg  <= '0;
            src_blk_ptr_reg  <= '0;
            dst_blk_ptr_reg  <= '0;
            src_row_step_reg <= '0;
            dst_row_step_reg <= '0;
            src_blk_step_reg <= '0;
            dst_blk_step_reg <= '0;
            row_bytes_reg    <= '0;
            out_vld_reg      <= 1'b0;
            out_src_reg      <= '0;
            out_dst_reg      <= '0;
            out_cnt_reg      <= '0;
            out_last_reg     <= 1'b0;
            out_status_reg   <= sbm_pkg::ST_STARTED;
        end
        else
        begin
            in_vld_reg       <= in_vld_next;
            in_op_reg        <= in_op_next;
            in_src_reg       <= in_src_next;
            in_dst_reg       <= in_dst_next;
            active_reg       <= active_next;
            row_idx_reg      <= row_idx_next;
            blk_idx_reg      <= blk_idx_next;
            src_row_ptr_reg  <= src_row_ptr_next;
            dst_row_ptr_reg  <= dst_row_ptr_next;
            src_blk_ptr_reg  <= src_blk_ptr_next;
            dst_blk_ptr_reg  <= dst_blk_ptr_next;
            src_row_step_reg <= src_row_step_next;
            dst_row_step_reg <= dst_row_step_next;
            src_blk_step_reg <= src_blk_step_next;
            dst_blk_step_reg <= dst_blk_step_next;
            row_bytes_reg    <= row_bytes_next;
            out_vld_reg      <= out_vld_next;
            out_src_reg      <= out_src_next;
            out_dst_reg      <= out_dst_next;
            out_cnt_reg      <= out_cnt_next;
            out_last_reg     <= out_last_next;
            out_status_reg   <= out_status_next;
        end
    end

    // a held beat is not dropped while the result side stalls
    `SBM_ASSERT_NEXT(a_hold_input, clk, rst_n, in_vld_reg && !proceed, in_vld_reg)

    // an advance during a transfer yields a row beat
    `SBM_ASSERT_NEXT(a_row_beat, clk, rst_n,
        proceed && in_op_reg == sbm_pkg::OP_ADVANCE && active_reg,
        out_vld_reg && out_status_reg == sbm_pkg::ST_ROW)

    // the final row ends the transfer
    `SBM_ASSERT_NEXT(a_last_ends, clk, rst_n,
        proceed && in_op_reg == sbm_pkg::OP_ADVANCE && active_reg && end_all,
        !active_reg && out_last_reg)

    // a bad element type never starts a transfer
    `SBM_ASSERT_NEXT(a_bad_type, clk, rst_n,
        proceed && in_op_reg == sbm_pkg::OP_START && !esz.ok,
        !active_reg && out_status_reg == sbm_pkg::ST_BAD_TYPE)

    // a result is only offered with the byte count of a row or none
    `SBM_ASSERT_SAME(a_idle_no_bytes, clk, rst_n,
        out_vld_reg && out_status_reg != sbm_pkg::ST_ROW,
        out_cnt_reg == '0 && !out_last_reg)

endmodule
